>>> rtl/core/fpda_pkg.sv
// ----------------------------------------------------------------------------
// fpda_pkg
// Shared constants and types for the fixed-point to decimal ascii core.
// ----------------------------------------------------------------------------
package fpda_pkg;

    // fixed-point format of the incoming value
    localparam int INT_BITS  = 16;
    localparam int FRAC_BITS = 8;
    localparam int VAL_BITS  = INT_BITS + FRAC_BITS;
    localparam int IN_TDATA_W = ((VAL_BITS + 7) / 8) * 8;

    // integer part after a possible carry from the hundredths
    localparam int IP_BITS = INT_BITS + 1;

    // number of decimal digits of a constant, worked out at elaboration
    function automatic int dec_digits(input longint x);
        int     n;
        longint t;
        n = 0;
        t = x;
        for (int k = 0; k < 20; k++) begin
            if (t > 0) begin
                t = t / 10;
                n = n + 1;
            end
        end
        return n;
    endfunction

    // largest printable integer part is 2^INT_BITS
    localparam int INT_DIGITS = dec_digits(longint'(1) << INT_BITS);
    localparam int DIG_W      = $clog2(INT_DIGITS);
    localparam int CNT_W      = $clog2(INT_DIGITS + 3);

    // hundredths product width: frac * 100 + half fits below 2^(FRAC_BITS+7)
    localparam int PROD_W    = FRAC_BITS + 7;
    localparam int HUND_MUL  = 100;
    localparam int HUND_HALF = 1 << (FRAC_BITS - 1);

    // double dabble stages
    localparam int DAB_STEPS  = 4;
    localparam int DAB_STAGES = (IP_BITS + DAB_STEPS - 1) / DAB_STEPS;
    localparam int NUM_STAGES = 2 + DAB_STAGES;

    // character codes
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_DOT  = 8'h2E;

    typedef logic [INT_DIGITS-1:0][3:0] t_bcd;

    // converted value handed from the pipeline to the character serializer
    typedef struct packed {
        t_bcd       int_digits;
        logic [3:0] tens;
        logic [3:0] ones;
    } t_conv_word;

endpackage

>>> rtl/core/fixed_point_to_decimal_ascii_core.sv
// ----------------------------------------------------------------------------
// fixed_point_to_decimal_ascii_core
// Formats an unsigned fixed-point value as decimal ascii text with two
// rounded decimal places, one character per output word.
// ----------------------------------------------------------------------------
// Each input word carries a value with 16 integer and 8 fraction bits; the
// core sends its text (integer digits without leading zeros, '.', two
// hundredths digits rounded half up) as 4 to 8 output words, tlast on the
// final digit. A hundredths value that rounds to 100 carries into the
// integer part. Conversion runs in a 7-stage pipeline that takes a word
// every cycle unless a stall holds it; the character serializer then sends
// a value's characters in turn and takes the next value with the final
// character, so that serializer sets the sustained rate. A value's first
// character goes out once it has left the pipeline and been loaded.
module fixed_point_to_decimal_ascii_core
    import fpda_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // slave side: value_fixed[VAL_BITS-1:0], zero padded to whole bytes
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_TDATA_W-1:0] i_s_tdata,
    // master side: char_code[7:0]
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [7:0]            o_m_tdata,
    output logic                  o_m_tlast
);

    // character positions counted down to the last one
    localparam logic [CNT_W-1:0] POS_ONES = CNT_W'(0);
    localparam logic [CNT_W-1:0] POS_TENS = CNT_W'(1);
    localparam logic [CNT_W-1:0] POS_DOT  = CNT_W'(2);
    localparam logic [CNT_W-1:0] POS_INT0 = CNT_W'(3);

    logic       w_conv_vld;
    logic       w_take;
    logic       w_load;
    t_conv_word w_conv_word;

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    t_conv_word       r_word;
    logic             n_busy;
    logic [CNT_W-1:0] n_cnt;

    logic             w_last;
    logic [CNT_W-1:0] w_ndig;
    logic [CNT_W-1:0] w_idx;
    logic [3:0]       w_digit;

    fpda_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_value (i_s_tdata[VAL_BITS-1:0]),
        .o_valid (w_conv_vld),
        .i_ready (w_take),
        .o_word  (w_conv_word)
    );

    // serializer takes a new word when idle or on the final character
    assign w_last = (r_cnt == POS_ONES);
    assign w_take = !r_busy || (w_last && i_m_tready);
    assign w_load = w_conv_vld && w_take;

    // significant integer digits, at least one
    always_comb begin
        w_ndig = CNT_W'(1);
        for (int k = 1; k < INT_DIGITS; k++) begin
            if (w_conv_word.int_digits[k] != 4'd0) begin
                w_ndig = CNT_W'(k + 1);
            end
        end
    end

    // character counter
    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        if (r_busy && i_m_tready) begin
            if (w_last) begin
                n_busy = 1'b0;
            end else begin
                n_cnt = r_cnt - CNT_W'(1);
            end
        end
        if (w_load) begin
            n_busy = 1'b1;
            n_cnt  = w_ndig + POS_DOT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= POS_ONES;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_word <= w_conv_word;
        end
    end

    // character select
    assign w_idx = r_cnt - POS_INT0;

    always_comb begin
        w_digit   = 4'd0;
        o_m_tdata = ASCII_DOT;
        if (r_cnt == POS_ONES) begin
            o_m_tdata = ASCII_ZERO + {4'd0, r_word.ones};
        end else if (r_cnt == POS_TENS) begin
            o_m_tdata = ASCII_ZERO + {4'd0, r_word.tens};
        end else if (r_cnt == POS_DOT) begin
            o_m_tdata = ASCII_DOT;
        end else begin
            w_digit   = r_word.int_digits[w_idx[DIG_W-1:0]];
            o_m_tdata = ASCII_ZERO + {4'd0, w_digit};
        end
    end

    assign o_m_tvalid = r_busy;
    assign o_m_tlast  = w_last;

`ifndef SYNTH
    // a sent point is followed by a hundredths digit that is not the last
    a_dot_then_tens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && (o_m_tdata == ASCII_DOT)
        |=> o_m_tvalid && !o_m_tlast)
        else $error("point not followed by tens digit");

    // the final character is a digit
    a_last_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> (o_m_tdata != ASCII_DOT))
        else $error("last character is the point");

    // a freshly loaded value starts with an integer digit
    a_first_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> o_m_tvalid && (o_m_tdata != ASCII_DOT) && !o_m_tlast)
        else $error("text does not start with a digit");
`endif

endmodule

>>> rtl/core/fpda_conv.sv
// ----------------------------------------------------------------------------
// fpda_conv
// Pipelined conversion of a fixed-point value into bcd integer digits and
// rounded hundredths digits, one word per stall-free cycle, with per-stage valid bits.
// ----------------------------------------------------------------------------
module fpda_conv
    import fpda_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [VAL_BITS-1:0] i_value,
    output logic                o_valid,
    input  logic                i_ready,
    output t_conv_word          o_word
);

    // one double dabble slice: up to DAB_STEPS shift steps
    function automatic logic [4*INT_DIGITS+IP_BITS-1:0] dab_slice(
        input t_bcd               bcd_in,
        input logic [IP_BITS-1:0] bin_in,
        input int                 nsteps
    );
        t_bcd               b;
        logic [IP_BITS-1:0] x;
        b = bcd_in;
        x = bin_in;
        for (int s = 0; s < DAB_STEPS; s++) begin
            if (s < nsteps) begin
                for (int k = 0; k < INT_DIGITS; k++) begin
                    if (b[k] >= 4'd5) begin
                        b[k] = b[k] + 4'd3;
                    end
                end
                {b, x} = {b, x} << 1;
            end
        end
        return {b, x};
    endfunction

    // split hundredths (below 100) into tens and ones by compare and subtract
    function automatic logic [7:0] split_hund(input logic [6:0] h);
        logic [6:0] r;
        logic [3:0] t;
        r = h;
        t = 4'd0;
        if (r >= 7'd80) begin
            r = r - 7'd80;
            t = t + 4'd8;
        end
        if (r >= 7'd40) begin
            r = r - 7'd40;
            t = t + 4'd4;
        end
        if (r >= 7'd20) begin
            r = r - 7'd20;
            t = t + 4'd2;
        end
        if (r >= 7'd10) begin
            r = r - 7'd10;
            t = t + 4'd1;
        end
        return {t, r[3:0]};
    endfunction

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES:0]   w_go;

    logic [PROD_W-1:0]   r_prod;
    logic [INT_BITS-1:0] r_ip0;
    logic [6:0]          r_hund;
    logic [IP_BITS-1:0]  r_ip1;

    logic [IP_BITS-1:0] r_bin  [DAB_STAGES];
    t_bcd               r_bcd  [DAB_STAGES];
    logic [3:0]         r_tens [DAB_STAGES];
    logic [3:0]         r_ones [DAB_STAGES];

    logic [PROD_W-1:0]  w_prod;
    logic [6:0]         w_hund_raw;
    logic               w_carry;
    logic [6:0]         w_hund;
    logic [IP_BITS-1:0] w_ip;

    // stage advance chain: a stage moves when it is empty or its successor moves
    always_comb begin
        w_go[NUM_STAGES] = i_ready;
        for (int k = NUM_STAGES - 1; k >= 0; k--) begin
            w_go[k] = !r_vld[k] || w_go[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NUM_STAGES; k++) begin
                if (w_go[k]) begin
                    r_vld[k] <= (k == 0) ? i_valid : r_vld[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    // stage 0: rounding product of the fraction
    assign w_prod = PROD_W'(i_value[FRAC_BITS-1:0]) * PROD_W'(HUND_MUL)
                  + PROD_W'(HUND_HALF);

    always_ff @(posedge i_clk) begin
        if (w_go[0]) begin
            r_prod <= w_prod;
            r_ip0  <= i_value[VAL_BITS-1:FRAC_BITS];
        end
    end

    // stage 1: hundredths and carry of a full hundred into the integer part
    assign w_hund_raw = r_prod[PROD_W-1:FRAC_BITS];
    assign w_carry    = (w_hund_raw >= 7'(HUND_MUL));
    assign w_hund     = w_carry ? 7'd0 : w_hund_raw;
    assign w_ip       = IP_BITS'(r_ip0) + IP_BITS'(w_carry);

    always_ff @(posedge i_clk) begin
        if (w_go[1]) begin
            r_hund <= w_hund;
            r_ip1  <= w_ip;
        end
    end

    // stages 2 and up: binary to bcd, up to DAB_STEPS shift steps per stage
    for (genvar d = 0; d < DAB_STAGES; d++) begin : g_dab
        localparam int LEFT   = IP_BITS - d * DAB_STEPS;
        localparam int NSTEPS = (LEFT < DAB_STEPS) ? LEFT : DAB_STEPS;

        logic [IP_BITS-1:0]           w_bin_src;
        t_bcd                         w_bcd_src;
        logic [3:0]                   w_tens_src;
        logic [3:0]                   w_ones_src;
        logic [4*INT_DIGITS+IP_BITS-1:0] w_res;

        if (d == 0) begin : g_first
            assign w_bin_src = r_ip1;
            assign w_bcd_src = '0;
            assign {w_tens_src, w_ones_src} = split_hund(r_hund);
        end else begin : g_next
            assign w_bin_src  = r_bin[d-1];
            assign w_bcd_src  = r_bcd[d-1];
            assign w_tens_src = r_tens[d-1];
            assign w_ones_src = r_ones[d-1];
        end

        assign w_res = dab_slice(w_bcd_src, w_bin_src, NSTEPS);

        always_ff @(posedge i_clk) begin
            if (w_go[2+d]) begin
                r_bcd[d]  <= w_res[4*INT_DIGITS+IP_BITS-1:IP_BITS];
                r_bin[d]  <= w_res[IP_BITS-1:0];
                r_tens[d] <= w_tens_src;
                r_ones[d] <= w_ones_src;
            end
        end
    end

    // output of the last stage
    assign o_ready           = w_go[0];
    assign o_valid           = r_vld[NUM_STAGES-1];
    assign o_word.int_digits = r_bcd[DAB_STAGES-1];
    assign o_word.tens       = r_tens[DAB_STAGES-1];
    assign o_word.ones       = r_ones[DAB_STAGES-1];

`ifndef SYNTH
    // hundredths digits leaving the pipeline are decimal digits
    a_hund_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_word.tens <= 4'd9) && (o_word.ones <= 4'd9))
        else $error("hundredths digit out of range");

    // a stalled output word stays in place
    a_hold_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_word))
        else $error("stalled output word changed");

    // input is held off only behind a stalled last stage
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("input blocked without a stall");
`endif

endmodule
